@@ rtl/bmtm_pkg.sv @@
// ----------------------------------------------------------------------------
// bmtm_pkg
// Shared types and constants for the battery mean threshold monitor.
// ----------------------------------------------------------------------------
package bmtm_pkg;

  // Field widths fixed by the stream and register formats
  localparam int unsigned IN_SAMPLE_W = 12;
  localparam int unsigned LEVEL_W     = 12;
  localparam int unsigned MEAN_W      = 12;
  localparam int unsigned CYCLE_W     = 32;
  localparam int unsigned CFG_IDX_W   = 4;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HIGH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MID  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 4'd3;

  // Register reset values
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH_RST = 12'd3000;
  localparam logic [LEVEL_W-1:0] LEVEL_MID_RST  = 12'd2900;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW_RST  = 12'd2800;
  localparam logic [LEVEL_W-1:0] HYSTERESIS_RST = 12'd20;

  // Per-level alarm action reported with each result
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_RAISE = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // One level's threshold setup
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] hyst;
  } level_cfg_t;

endpackage

@@ rtl/bmtm_window.sv @@
// ----------------------------------------------------------------------------
// bmtm_window
// Shift line of the last WINDOW samples with a running sum kept in step.
// ----------------------------------------------------------------------------
module bmtm_window #(
  parameter int unsigned WINDOW      = 20,
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned SUM_W       = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SUM_W-1:0]       sum
);

  logic [SAMPLE_BITS-1:0] taps [WINDOW];
  logic [SUM_W-1:0]       sum_next;

  // oldest sample drops out as the new one enters
  assign sum_next = sum - SUM_W'(taps[WINDOW-1]) + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        taps[i] <= '0;
      end
    end else if (load) begin
      sum     <= sum_next;
      taps[0] <= sample;
      for (int i = 1; i < WINDOW; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

endmodule

@@ rtl/bmtm_level_judge.sv @@
// ----------------------------------------------------------------------------
// bmtm_level_judge
// Hysteresis decision for one level: raise below level minus margin,
// clear above level, otherwise none.
// ----------------------------------------------------------------------------
module bmtm_level_judge #(
  parameter int unsigned MEAN_BITS = 12
) (
  input  logic [MEAN_BITS-1:0] mean,
  input  bmtm_pkg::level_cfg_t cfg,
  output bmtm_pkg::action_t    action
);

  localparam int unsigned CMP_W =
    (MEAN_BITS > bmtm_pkg::LEVEL_W) ? MEAN_BITS : bmtm_pkg::LEVEL_W;

  logic [bmtm_pkg::LEVEL_W-1:0] thr;
  logic [CMP_W-1:0]             mean_ext;

  // threshold saturates at zero when the margin exceeds the level
  assign thr      = (cfg.level > cfg.hyst) ? (cfg.level - cfg.hyst) : '0;
  assign mean_ext = CMP_W'(mean);

  always_comb begin
    priority if (mean_ext < CMP_W'(thr)) begin
      action = bmtm_pkg::ACT_RAISE;
    end else if (mean_ext > CMP_W'(cfg.level)) begin
      action = bmtm_pkg::ACT_CLEAR;
    end else begin
      action = bmtm_pkg::ACT_NONE;
    end
  end

endmodule

@@ rtl/battery_mean_threshold_monitor_core.sv @@
// ----------------------------------------------------------------------------
// battery_mean_threshold_monitor_core
// Windowed mean of battery ADC samples with three hysteresis alarm levels.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload                                   transfer when
//  -------  ---------  ----------------------------------------  -----------------------
//  s_*      in         sample, cycle_number                      s_tvalid & s_tready
//  m_*      out        mean, on_battery, 3 actions, alarm_cycle  m_tvalid & m_tready
//  cfg_*    in         register index, 12-bit value              cfg_valid & cfg_ready
//
//  One item per clock sustained while the output is not stalled. An input transfer
//  updates the sample window and running sum in the window stage; the result register
//  then takes the mean (reciprocal multiply) and the level decisions.
//  Reset clears the window, the sum, the on-battery flag and the registers
//  to their defaults. A stalled output holds its result; the stage behind it
//  keeps one more item, so s_tready drops only when both are full.
//  cfg_ready is always high; out-of-range register indexes are ignored.
//
module battery_mean_threshold_monitor_core #(
  parameter int unsigned WINDOW      = 20,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,

  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [11:0] sample, [43:12] cycle_number, [47:44] zero

  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [11:0] mean_voltage, [12] on_battery,
                                 // [14:13] high_action, [16:15] mid_action,
                                 // [18:17] low_action, [50:19] alarm_cycle,
                                 // [55:51] zero

  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bmtm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmtm_pkg::LEVEL_W-1:0]   cfg_data
);

  // Mean = sum / WINDOW as an exact reciprocal multiply:
  // M = ceil(2^S / WINDOW) with S = sum width + ceil(log2 WINDOW) is exact
  // for every sum the window can hold.
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int unsigned DIV_SH = SUM_W + $clog2(WINDOW);
  localparam int unsigned MUL_W  = SUM_W + 1;
  localparam int unsigned PROD_W = SUM_W + MUL_W;
  localparam logic [63:0] DIV_MUL_FULL =
    ((64'd1 << DIV_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MUL_W-1:0] DIV_MUL = DIV_MUL_FULL[MUL_W-1:0];
  localparam int unsigned MEAN_EXT_W =
    (SAMPLE_BITS > bmtm_pkg::MEAN_W) ? SAMPLE_BITS : bmtm_pkg::MEAN_W;

  // configuration registers
  logic [bmtm_pkg::LEVEL_W-1:0] level_high;
  logic [bmtm_pkg::LEVEL_W-1:0] level_mid;
  logic [bmtm_pkg::LEVEL_W-1:0] level_low;
  logic [bmtm_pkg::LEVEL_W-1:0] hysteresis;

  // window stage
  logic                         s1_valid;
  logic [bmtm_pkg::CYCLE_W-1:0] s1_cycle;
  logic [SUM_W-1:0]             s1_sum;
  logic                         s1_load;
  logic                         s1_advance;
  logic [SAMPLE_BITS-1:0]       in_sample;

  // mean and decisions
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] mean;
  logic [MEAN_EXT_W-1:0]  mean_ext;
  bmtm_pkg::level_cfg_t   cfg_high, cfg_mid, cfg_low;
  bmtm_pkg::action_t      act_high, act_mid, act_low;
  logic                   any_raise;
  logic                   battery_flag;
  logic                   battery_flag_next;

  // result register
  logic [bmtm_pkg::MEAN_W-1:0]  out_mean;
  logic                         out_on_battery;
  bmtm_pkg::action_t            out_high, out_mid, out_low;
  logic [bmtm_pkg::CYCLE_W-1:0] out_cycle;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_high <= bmtm_pkg::LEVEL_HIGH_RST;
      level_mid  <= bmtm_pkg::LEVEL_MID_RST;
      level_low  <= bmtm_pkg::LEVEL_LOW_RST;
      hysteresis <= bmtm_pkg::HYSTERESIS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bmtm_pkg::REG_LEVEL_HIGH: level_high <= cfg_data;
        bmtm_pkg::REG_LEVEL_MID:  level_mid  <= cfg_data;
        bmtm_pkg::REG_LEVEL_LOW:  level_low  <= cfg_data;
        bmtm_pkg::REG_HYSTERESIS: hysteresis <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  // stage 1 moves on when the result register is empty or being drained
  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign s1_load    = s_tvalid && s_tready;

  // narrower sample width masks the field, wider zero-extends it
  assign in_sample = SAMPLE_BITS'(s_tdata[bmtm_pkg::IN_SAMPLE_W-1:0]);

  bmtm_window #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .load   (s1_load),
    .sample (in_sample),
    .sum    (s1_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_cycle <= s_tdata[bmtm_pkg::IN_SAMPLE_W +: bmtm_pkg::CYCLE_W];
    end
  end

  // ---------------- mean and level checks ----------------
  assign prod     = PROD_W'(s1_sum) * PROD_W'(DIV_MUL);
  assign mean     = prod[DIV_SH +: SAMPLE_BITS];
  assign mean_ext = MEAN_EXT_W'(mean);

  assign cfg_high = '{level: level_high, hyst: hysteresis};
  assign cfg_mid  = '{level: level_mid,  hyst: hysteresis};
  assign cfg_low  = '{level: level_low,  hyst: hysteresis};

  bmtm_level_judge #(.MEAN_BITS(SAMPLE_BITS)) u_judge_high (
    .mean (mean), .cfg (cfg_high), .action (act_high)
  );
  bmtm_level_judge #(.MEAN_BITS(SAMPLE_BITS)) u_judge_mid (
    .mean (mean), .cfg (cfg_mid), .action (act_mid)
  );
  bmtm_level_judge #(.MEAN_BITS(SAMPLE_BITS)) u_judge_low (
    .mean (mean), .cfg (cfg_low), .action (act_low)
  );

  assign any_raise = (act_high == bmtm_pkg::ACT_RAISE) ||
                     (act_mid  == bmtm_pkg::ACT_RAISE) ||
                     (act_low  == bmtm_pkg::ACT_RAISE);

  // high level drives the on-battery flag with the same hysteresis
  always_comb begin
    unique case (act_high)
      bmtm_pkg::ACT_RAISE: battery_flag_next = 1'b1;
      bmtm_pkg::ACT_CLEAR: battery_flag_next = 1'b0;
      default:             battery_flag_next = battery_flag;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      battery_flag <= 1'b0;
    end else if (s1_advance) begin
      battery_flag <= battery_flag_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_mean       <= mean_ext[bmtm_pkg::MEAN_W-1:0];
      out_on_battery <= battery_flag_next;
      out_high       <= act_high;
      out_mid        <= act_mid;
      out_low        <= act_low;
      out_cycle      <= any_raise ? s1_cycle : '0;
    end
  end

  assign m_tdata = {5'b0, out_cycle, out_low, out_mid, out_high,
                    out_on_battery, out_mean};

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for the battery mean threshold monitor core. A scoreboard keeps
// its own sample window, running sum and on-battery flag, predicts the mean
// and the three level actions for every input transfer, and checks each
// result transfer field by field. Directed samples come first. Phases of
// shaped random samples follow under several level/hysteresis settings, with
// random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import bmtm_pkg::*;

  localparam int unsigned WINDOW       = 20;
  localparam int unsigned NUM_REGS     = 4;     // indexes at or above this are ignored
  localparam int unsigned PIPE_DEPTH   = 2;     // input transfer to result
  localparam int unsigned LONG_HOLD    = 64;    // output stall that backs up the input
  localparam int unsigned STALL_LIMIT  = 1000;  // cycles with no transfer at all
  localparam int unsigned PHASE_ITEMS  = 110;
  localparam int unsigned NUM_PHASES   = 7;
  localparam int unsigned PRESSURE_PHASE = 4;
  localparam int unsigned MAX_PRINTS   = 30;

  // One result, laid out as m_tdata[50:0] (first member is the top)
  typedef struct packed {
    logic [CYCLE_W-1:0] alarm_cycle;
    action_t            low_act;
    action_t            mid_act;
    action_t            high_act;
    logic               on_batt;
    logic [MEAN_W-1:0]  mean;
  } monitor_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the window and flag, predicts, checks
  // --------------------------------------------------------------------------
  class mean_alarm_scoreboard;
    logic [IN_SAMPLE_W-1:0] ring [WINDOW];
    logic [4:0]             wr_idx;
    logic [16:0]            sum;
    logic                   batt;
    logic [LEVEL_W-1:0]     regs [NUM_REGS];
    monitor_result_t        expected_readings [$];
    int unsigned            checked, errors, raises, clears, batt_results;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_idx = '0;
      sum    = '0;
      batt   = 1'b0;
      regs[REG_LEVEL_HIGH] = LEVEL_HIGH_RST;
      regs[REG_LEVEL_MID]  = LEVEL_MID_RST;
      regs[REG_LEVEL_LOW]  = LEVEL_LOW_RST;
      regs[REG_HYSTERESIS] = HYSTERESIS_RST;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] value);
      if (idx < NUM_REGS) regs[idx[1:0]] = value;
    endfunction

    // Raise below (level - hyst), saturated at zero; clear above the level
    function action_t level_action(logic [MEAN_W-1:0] mean, logic [LEVEL_W-1:0] level);
      logic [LEVEL_W-1:0] thr;
      thr = (level > regs[REG_HYSTERESIS]) ? level - regs[REG_HYSTERESIS] : '0;
      if (mean < thr) return ACT_RAISE;
      if (mean > level) return ACT_CLEAR;
      return ACT_NONE;
    endfunction

    function void take_sample(logic [IN_SAMPLE_W-1:0] smp, logic [CYCLE_W-1:0] cyc);
      monitor_result_t r;
      logic [16:0]     quot;
      sum = sum - 17'(ring[wr_idx]) + 17'(smp);
      ring[wr_idx] = smp;
      wr_idx = (wr_idx == WINDOW - 1) ? '0 : wr_idx + 1'b1;
      quot = 17'(sum / WINDOW);
      r.mean     = quot[MEAN_W-1:0];
      r.high_act = level_action(r.mean, regs[REG_LEVEL_HIGH]);
      r.mid_act  = level_action(r.mean, regs[REG_LEVEL_MID]);
      r.low_act  = level_action(r.mean, regs[REG_LEVEL_LOW]);
      if (r.high_act == ACT_RAISE) batt = 1'b1;
      else if (r.high_act == ACT_CLEAR) batt = 1'b0;
      r.on_batt = batt;
      r.alarm_cycle = (r.high_act == ACT_RAISE || r.mid_act == ACT_RAISE ||
                       r.low_act == ACT_RAISE) ? cyc : '0;
      expected_readings.push_back(r);
    endfunction

    function int unsigned pending();
      return expected_readings.size();
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [55:0] word);
      monitor_result_t got, exp;
      got = monitor_result_t'(word[50:0]);
      if (expected_readings.size() == 0) begin
        report_mismatch("result transfer with no item outstanding");
      end else begin
        exp = expected_readings.pop_front();
        if (got.mean !== exp.mean)
          report_mismatch($sformatf("result %0d mean_voltage %0d, expected %0d",
                                    checked, got.mean, exp.mean));
        if (got.on_batt !== exp.on_batt)
          report_mismatch($sformatf("result %0d on_battery %0b, expected %0b",
                                    checked, got.on_batt, exp.on_batt));
        if (got.high_act !== exp.high_act)
          report_mismatch($sformatf("result %0d high_action %0d, expected %0d",
                                    checked, got.high_act, exp.high_act));
        if (got.mid_act !== exp.mid_act)
          report_mismatch($sformatf("result %0d mid_action %0d, expected %0d",
                                    checked, got.mid_act, exp.mid_act));
        if (got.low_act !== exp.low_act)
          report_mismatch($sformatf("result %0d low_action %0d, expected %0d",
                                    checked, got.low_act, exp.low_act));
        if (got.alarm_cycle !== exp.alarm_cycle)
          report_mismatch($sformatf("result %0d alarm_cycle %h, expected %h",
                                    checked, got.alarm_cycle, exp.alarm_cycle));
        raises += (exp.high_act == ACT_RAISE) + (exp.mid_act == ACT_RAISE) +
                  (exp.low_act == ACT_RAISE);
        clears += (exp.high_act == ACT_CLEAR) + (exp.mid_act == ACT_CLEAR) +
                  (exp.low_act == ACT_CLEAR);
        batt_results += exp.on_batt;
        checked++;
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [47:0]          s_tdata;   // [11:0] sample, [43:12] cycle_number, [47:44] zero
  logic                 m_tvalid;
  logic                 m_tready;
  logic [55:0]          m_tdata;   // [11:0] mean_voltage, [12] on_battery,
                                   // [14:13] high_action, [16:15] mid_action,
                                   // [18:17] low_action, [50:19] alarm_cycle
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0]   cfg_data;

  mean_alarm_scoreboard sb;
  int unsigned          tx_gap_max;
  int unsigned          rx_gap_max;
  logic                 pressure_arm;
  int unsigned          quiet_cycles;
  int unsigned          sent_items;
  int unsigned          settings_applied;
  int                   cfg_val [NUM_REGS];   // current levels, used to aim samples
  logic [CYCLE_W-1:0]   cycle_no;

  battery_mean_threshold_monitor_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, sb.pending());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall after each transfer, plus one long hold-off
  initial begin : result_sink
    int unsigned wait_left;
    bit          hold_done;
    wait_left = 0;
    hold_done = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (m_tvalid && m_tready) begin
          sb.check_result(m_tdata);
          wait_left = (rx_gap_max == 0) ? 0 : $urandom_range(rx_gap_max, 0);
        end
        if (pressure_arm && !hold_done) begin
          wait_left = LONG_HOLD;
          hold_done = 1'b1;
        end
        m_tready <= (wait_left == 0);
        if (wait_left != 0) wait_left--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks (entered and left just after a rising edge)
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [IN_SAMPLE_W-1:0] smp, input logic [CYCLE_W-1:0] cyc);
    int unsigned gap;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max, 0);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, cyc, smp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_sample(smp, cyc);
    sent_items++;
  endtask

  // valid stays high across back-to-back writes; the caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, value);
    if (idx < NUM_REGS) cfg_val[idx[1:0]] = value;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic program_levels(input logic [LEVEL_W-1:0] lh, input logic [LEVEL_W-1:0] lm,
                                input logic [LEVEL_W-1:0] ll, input logic [LEVEL_W-1:0] hy);
    wait_idle();
    write_reg(REG_LEVEL_HIGH, lh);
    write_reg(REG_LEVEL_MID, lm);
    write_reg(REG_LEVEL_LOW, ll);
    write_reg(REG_HYSTERESIS, hy);
    // out-of-range index: must leave every register alone
    write_reg(CFG_IDX_W'($urandom_range(15, NUM_REGS)), LEVEL_W'($urandom));
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  function automatic int clamp_sample(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // Aim at the interesting edges of a level: the level itself, just above,
  // the raise threshold, just below it, the middle of the hysteresis band, or anywhere
  function automatic int pick_target();
    int lv, hy;
    lv = cfg_val[2'($urandom_range(2, 0))];
    hy = cfg_val[REG_HYSTERESIS];
    case ($urandom_range(5, 0))
      0:       return clamp_sample(lv);
      1:       return clamp_sample(lv + 1);
      2:       return clamp_sample(lv - hy);
      3:       return clamp_sample(lv - hy - 1);
      4:       return clamp_sample(lv - hy / 2);
      default: return $urandom_range(4095, 0);
    endcase
  endfunction

  // Segments of samples held near a target with small noise, so the mean
  // settles on and drifts across thresholds; some uniform and rail noise
  task automatic run_random(input int unsigned n);
    int unsigned seg_left, mode, k;
    int          tgt, smp;
    seg_left = 0;
    repeat (n) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 5);
        mode     = $urandom_range(99, 0);
        tgt      = pick_target();
        case ($urandom_range(3, 0))
          0:       k = 0;
          1:       k = 1;
          2:       k = 3;
          default: k = 8;
        endcase
      end
      seg_left--;
      if (mode < 70)      smp = clamp_sample(tgt + int'($urandom_range(2 * k, 0)) - int'(k));
      else if (mode < 85) smp = $urandom_range(4095, 0);
      else                smp = $urandom_range(1, 0) ? 4095 : 0;
      cycle_no = ($urandom_range(7, 0) == 0) ? CYCLE_W'($urandom) : cycle_no + 1'b1;
      send_item(IN_SAMPLE_W'(smp), cycle_no);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [LEVEL_W-1:0] lh, lm, ll, hy;
    int unsigned        txg, rxg;
    sb = new();
    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    pressure_arm <= 1'b0;
    rx_gap_max   <= 18;
    tx_gap_max   = 18;
    sent_items   = 0;
    settings_applied = 1;
    cycle_no     = '0;
    cfg_val[REG_LEVEL_HIGH] = LEVEL_HIGH_RST;
    cfg_val[REG_LEVEL_MID]  = LEVEL_MID_RST;
    cfg_val[REG_LEVEL_LOW]  = LEVEL_LOW_RST;
    cfg_val[REG_HYSTERESIS] = HYSTERESIS_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, default levels: rails and alternating bit patterns on an
    // empty window (all levels raise, flag sets), then fill with full scale
    // so every level clears and the flag drops
    send_item(12'hFFF, 32'hFFFF_FFFF);
    send_item(12'h000, 32'h0000_0000);
    send_item(12'hAAA, 32'hAAAA_AAAA);
    send_item(12'h555, 32'h5555_5555);
    repeat (WINDOW) begin
      cycle_no = cycle_no + 1'b1;
      send_item(12'hFFF, cycle_no);
    end
    send_item(12'h000, 32'h0000_0001);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          lh = 12'd3400; lm = 12'd3000; ll = 12'd2600; hy = 12'd50; txg = 18; rxg = 18;
        end
        1: begin
          // full-scale high, zero low, no hysteresis; no idling
          lh = 12'd4095; lm = 12'd2048; ll = 12'd0; hy = 12'd0; txg = 0; rxg = 0;
        end
        2: begin
          lh = LEVEL_W'($urandom); lm = LEVEL_W'($urandom); ll = LEVEL_W'($urandom);
          hy = LEVEL_W'($urandom); txg = 4; rxg = 18;
        end
        3: begin
          // hysteresis at or above every level: thresholds pinned at zero, never raise
          lh = LEVEL_W'($urandom_range(4095, 2048)); lm = LEVEL_W'($urandom_range(2047, 1024));
          ll = LEVEL_W'($urandom_range(1023, 0)); hy = 12'd4095; txg = 18; rxg = 0;
        end
        PRESSURE_PHASE: begin
          lh = LEVEL_HIGH_RST; lm = LEVEL_MID_RST; ll = LEVEL_LOW_RST; hy = HYSTERESIS_RST;
          txg = 0; rxg = 4;
        end
        5: begin
          // zero high level, full-scale mid, low level under its hysteresis
          lh = 12'd0; lm = 12'd4095; ll = 12'd100; hy = 12'd200; txg = 18; rxg = 18;
        end
        default: begin
          lh = LEVEL_W'($urandom); lm = LEVEL_W'($urandom); ll = LEVEL_W'($urandom);
          hy = LEVEL_W'($urandom_range(400, 0));
          txg = $urandom_range(1, 0) ? 18 : 0; rxg = $urandom_range(1, 0) ? 18 : 0;
        end
      endcase
      program_levels(lh, lm, ll, hy);
      tx_gap_max = txg;
      rx_gap_max <= rxg;
      if (ph == PRESSURE_PHASE) pressure_arm <= 1'b1;
      run_random(PHASE_ITEMS);
    end

    wait_idle();
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

    $display("Covered %0d samples and %0d results across %0d level settings.",
             sent_items, sb.checked, settings_applied);
    $display("Level actions checked: %0d raises, %0d clears; on-battery set in %0d results.",
             sb.raises, sb.clears, sb.batt_results);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ battery_mean_threshold_monitor_core.f @@
rtl/bmtm_pkg.sv
rtl/bmtm_window.sv
rtl/bmtm_level_judge.sv
rtl/battery_mean_threshold_monitor_core.sv
dv/tb.sv
